// ===== hdl/hte_pkg.sv =====
// Shared types, character codes and small lookup functions of the hex text
// frame encoder. No dependencies; used by every module of the block.

package hte_pkg;

   localparam logic [13:0] MAX_LEN = 14'd9999;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [3:0] HDR_LAST = 4'd11;
   localparam logic [0:0] KIND_START = 1'b0;
   localparam logic [0:0] KIND_DATA  = 1'b1;

   // One classified request handed from the front to the back.
   typedef struct packed {
      logic        is_start;
      logic [13:0] length;     // saturated length, start only
      logic [1:0]  first_dig;  // index of the leading printed digit
      logic [7:0]  data;       // data byte, data only
      logic        close;      // the line ends after this request
   } cmd_type;

   function automatic logic [7:0] hdr_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h47;
         4'd1:    c = 8'h42;
         4'd2:    c = 8'h43;
         4'd3:    c = 8'h53;
         4'd4:    c = 8'h3A;
         4'd5:    c = 8'h44;
         4'd6:    c = 8'h41;
         4'd7:    c = 8'h54;
         4'd8:    c = 8'h41;
         4'd9:    c = 8'h23;
         4'd10:   c = 8'h30;
         default: c = 8'h3A;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] c;
      if (v < 4'd10) begin
         c = CH_ZERO + {4'd0, v};
      end else begin
         c = CH_UPA + {4'd0, v - 4'd10};
      end
      return c;
   endfunction

   // Decimal weight of digit position 0 (thousands) to 3 (ones).
   function automatic logic [13:0] dig_weight(input logic [1:0] pos);
      logic [13:0] w;
      unique case (pos)
         2'd0:    w = 14'd1000;
         2'd1:    w = 14'd100;
         2'd2:    w = 14'd10;
         default: w = 14'd1;
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/hex_text_frame_encoder.sv =====
// Top level of the hex text frame encoder: front part, command queue and
// back part. Depends on hte_pkg, hte_front, hte_fifo and hte_back.
//
// Usage: requests enter through a queue-like port (req_push / req_full).
// A start request (req_type 0) carries req_msg_length, saturated to 9999;
// it yields the fixed twelve-character header, the length in decimal,
// ':' and, for an empty message, CR LF. Each data request (req_type 1)
// yields two upper-case hex digits, plus CR LF after the last declared
// byte. A data request with no message open is taken and dropped.
// Characters leave through rsp_empty / rsp_pop, oldest first, with
// rsp_run_last on the last character of a request and rsp_line_end on
// the closing LF.
// Path: a request passes through the command queue and the back part's
// phase register before its first character enters the result register.
// Throughput is one character per cycle while the receiver pops, set by
// the single character sequencer of the back part.
// A four-entry command queue lets requests be taken while the back part is
// busy or the receiver stalls; req_full rises when that queue is full.
// Reset closes any open message and empties the queue and result register.

module hex_text_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_type,
   input  logic [13:0] req_msg_length,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_run_last,
   output logic        rsp_line_end
);

   hte_pkg::cmd_type wr_cmd, rd_cmd;
   logic q_push, q_full, q_pop, q_empty;

   hte_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_type       (req_type),
      .req_msg_length (req_msg_length),
      .req_data_byte  (req_data_byte),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (wr_cmd)
   );

   hte_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (wr_cmd),
      .full   (q_full),
      .pop    (q_pop),
      .rd_cmd (rd_cmd),
      .empty  (q_empty)
   );

   hte_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_cmd        (rd_cmd),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last),
      .rsp_line_end (rsp_line_end)
   );

endmodule

// ===== hdl/hte_front.sv =====
// Front part: accepts requests, tracks the bytes still expected and turns
// each request into a command for the queue. Depends on hte_pkg.

module hte_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_type,
   input  logic [13:0]      req_msg_length,
   input  logic [7:0]       req_data_byte,
   input  logic             q_full,
   output logic             q_push,
   output hte_pkg::cmd_type q_cmd
);

   logic [13:0] bytes_left_ff, bytes_left_in;
   logic [13:0] len_sat;
   logic        accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      len_sat = (req_msg_length > hte_pkg::MAX_LEN) ? hte_pkg::MAX_LEN : req_msg_length;
      bytes_left_in   = bytes_left_ff;
      q_push          = 1'b0;
      q_cmd.is_start  = (req_type == hte_pkg::KIND_START);
      q_cmd.length    = len_sat;
      q_cmd.data      = req_data_byte;
      q_cmd.close     = 1'b0;
      priority if (len_sat > 14'd999) begin
         q_cmd.first_dig = 2'd0;
      end else if (len_sat > 14'd99) begin
         q_cmd.first_dig = 2'd1;
      end else if (len_sat > 14'd9) begin
         q_cmd.first_dig = 2'd2;
      end else begin
         q_cmd.first_dig = 2'd3;
      end
      if (accept) begin
         if (req_type == hte_pkg::KIND_START) begin
            q_push        = 1'b1;
            q_cmd.close   = (len_sat == 14'd0);
            bytes_left_in = len_sat;
         end else if (bytes_left_ff != 14'd0) begin
            // A data byte with no message open is dropped here.
            q_push        = 1'b1;
            q_cmd.close   = (bytes_left_ff == 14'd1);
            bytes_left_in = bytes_left_ff - 14'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 14'd0;
      end else begin
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

// ===== hdl/hte_fifo.sv =====
// Four-entry command queue between the front and the back parts.
// Depends on hte_pkg for the command type.

module hte_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hte_pkg::cmd_type wr_cmd,
   output logic             full,
   input  logic             pop,
   output hte_pkg::cmd_type rd_cmd,
   output logic             empty
);

   hte_pkg::cmd_type mem_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;
   logic       do_push, do_pop;

   assign full    = (count_ff == 3'd4);
   assign empty   = (count_ff == 3'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_cmd  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 2'd1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 3'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 3'd1;
         end
      end
   end

endmodule

// ===== hdl/hte_back.sv =====
// Back part: takes commands from the queue and emits one character per
// cycle into the result register while it is free. Depends on hte_pkg.

module hte_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  hte_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_line_end
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_HDR, PH_DIG, PH_COLON, PH_HI, PH_LO, PH_CR, PH_LF
   } phase_type;

   phase_type   phase_ff, phase_in, ph_nx;
   logic [3:0]  idx_ff, idx_in, idx_nx;
   logic        close_ff;
   logic [1:0]  first_ff;
   logic [7:0]  data_ff;
   logic [13:0] rem_ff;
   logic [1:0]  dpos_ff;
   logic        drun_ff;
   logic [3:0]  dig_ff [4];
   logic [3:0]  dig_val;
   logic [13:0] dig_w;

   logic        valid_ff;
   logic [7:0]  char_ff, char_sel;
   logic        last_ff, last_sel;
   logic        lend_ff, lend_sel;
   logic        out_free, emit, take;

   assign rsp_empty    = !valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_run_last = last_ff;
   assign rsp_line_end = lend_ff;

   // One decimal digit per cycle by parallel compares against its multiples.
   always_comb begin
      dig_w   = hte_pkg::dig_weight(dpos_ff);
      dig_val = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem_ff >= 14'(k) * dig_w) begin
            dig_val = 4'(k);
         end
      end
   end

   always_comb begin
      char_sel = hte_pkg::CH_CR;
      last_sel = 1'b0;
      lend_sel = 1'b0;
      ph_nx    = PH_IDLE;
      idx_nx   = idx_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            ph_nx = PH_IDLE;
         end
         PH_HDR: begin
            char_sel = hte_pkg::hdr_char(idx_ff);
            if (idx_ff == hte_pkg::HDR_LAST) begin
               ph_nx  = PH_DIG;
               idx_nx = {2'd0, first_ff};
            end else begin
               ph_nx  = PH_HDR;
               idx_nx = idx_ff + 4'd1;
            end
         end
         PH_DIG: begin
            char_sel = hte_pkg::CH_ZERO + {4'd0, dig_ff[idx_ff[1:0]]};
            ph_nx    = (idx_ff[1:0] == 2'd3) ? PH_COLON : PH_DIG;
            idx_nx   = idx_ff + 4'd1;
         end
         PH_COLON: begin
            char_sel = hte_pkg::CH_COLON;
            last_sel = !close_ff;
            ph_nx    = close_ff ? PH_CR : PH_IDLE;
         end
         PH_HI: begin
            char_sel = hte_pkg::hex_char(data_ff[7:4]);
            ph_nx    = PH_LO;
         end
         PH_LO: begin
            char_sel = hte_pkg::hex_char(data_ff[3:0]);
            last_sel = !close_ff;
            ph_nx    = close_ff ? PH_CR : PH_IDLE;
         end
         PH_CR: begin
            char_sel = hte_pkg::CH_CR;
            ph_nx    = PH_LF;
         end
         PH_LF: begin
            char_sel = hte_pkg::CH_LF;
            last_sel = 1'b1;
            lend_sel = 1'b1;
            ph_nx    = PH_IDLE;
         end
         default: begin
            ph_nx = PH_IDLE;
         end
      endcase

      out_free = !valid_ff || rsp_pop;
      emit     = (phase_ff != PH_IDLE) && out_free;
      // The next request loads in the cycle that emits the last character.
      take     = (phase_ff == PH_IDLE || (emit && ph_nx == PH_IDLE)) && !q_empty;
      q_pop    = take;

      phase_in = phase_ff;
      idx_in   = idx_ff;
      if (take) begin
         phase_in = q_cmd.is_start ? PH_HDR : PH_HI;
         idx_in   = 4'd0;
      end else if (emit) begin
         phase_in = ph_nx;
         idx_in   = idx_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         close_ff <= q_cmd.close;
         first_ff <= q_cmd.first_dig;
         data_ff  <= q_cmd.data;
      end
      if (take && q_cmd.is_start) begin
         rem_ff  <= q_cmd.length;
         dpos_ff <= 2'd0;
      end else if (drun_ff) begin
         dig_ff[dpos_ff] <= dig_val;
         rem_ff  <= rem_ff - 14'(dig_val) * dig_w;
         dpos_ff <= dpos_ff + 2'd1;
      end
      if (emit) begin
         char_ff <= char_sel;
         last_ff <= last_sel;
         lend_ff <= lend_sel;
      end
      if (reset) begin
         phase_ff <= PH_IDLE;
         idx_ff   <= 4'd0;
         drun_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         if (take && q_cmd.is_start) begin
            drun_ff <= 1'b1;
         end else if (drun_ff && dpos_ff == 2'd3) begin
            drun_ff <= 1'b0;
         end
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule
